// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a given clock and active-low reset
`define MSC_ASSERT_CLK(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// same, on the block clock and reset
`define MSC_ASSERT(lbl, prop, msg) `MSC_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ===== rtl/msc_pkg.sv =====
package msc_pkg;

	localparam int VALUE_W       = 40;
	localparam int MOD_W         = 31;
	localparam int RES_W         = 30;
	localparam int COUNT_W       = 16;
	localparam int MAX_ITEMS_DEF = 16;

	localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(32'd16777216);
	localparam logic [MOD_W-1:0] MOD_LIMIT = MOD_W'(32'd1073741824);

	// request to the remainder unit
	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] dividend;
		logic [MOD_W-1:0]   divisor;
	} div_req_t;

endpackage

// ===== rtl/msc_divider.sv =====
module msc_divider
	import msc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [RES_W-1:0] rem
);

	localparam int IW = $clog2(VALUE_W + 1);

	logic [IW-1:0]      iter_q;
	logic               done_q;
	logic [VALUE_W-1:0] dvd_q;
	logic [RES_W-1:0]   rem_q;
	logic [MOD_W-1:0]   trial;
	logic [RES_W-1:0]   rem_nxt;

	// one quotient bit per cycle, restoring form, remainder only
	always_comb begin
		trial = {rem_q, dvd_q[VALUE_W-1]};
		if (trial >= req.divisor) begin
			rem_nxt = RES_W'(trial - req.divisor);
		end else begin
			rem_nxt = RES_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				iter_q <= IW'(VALUE_W);
			end else if (iter_q != '0) begin
				iter_q <= iter_q - IW'(1);
				if (iter_q == IW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
		end else if (iter_q != '0) begin
			dvd_q <= {dvd_q[VALUE_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/modular_subset_sum_counter_core.sv =====
// Modular subset-sum counter. Weights arrive one per start pulse with last low;
// each is reduced modulo the configured modulus (zero acts as 1, values above
// 2^30 act as 2^30) by a bit-serial remainder unit and written to the weight
// memory. Weights beyond MAX_ITEMS are dropped and flagged. The item with last
// high carries the target; the block then re-reduces every stored weight with
// the current modulus, walks all non-empty subsets in Gray-code order (one
// weight added or removed per cycle, read through the registered memory
// port) and counts the subsets whose sum matches the target modulo the
// modulus. One result is shown on done for one cycle and the receiver cannot
// stall it; the block is ready for the next item in that same cycle. A
// weight item keeps busy high through the remainder unit's iterations, one
// per dividend bit, and the memory write. A target item with stored weights
// first takes the target remainder, then for each weight a read, a start and
// a remainder, then one subset per cycle through the memory read port plus
// the final counter check, and a drain of the add and compare stages.
// A target with no stored weights raises done once its remainder is in,
// with count 0.
module modular_subset_sum_counter_core
	import msc_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               start,
	output logic               busy,
	input  logic [VALUE_W-1:0] value,
	input  logic               last,
	// result channel
	output logic               done,
	output logic [COUNT_W-1:0] match_count,
	output logic               found,
	output logic               too_many_items,
	// modulus register
	input  logic               modulus_we,
	input  logic [MOD_W-1:0]   modulus_wdata
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int KW = MAX_ITEMS + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WDIV,
		S_TDIV,
		S_RREAD,
		S_RSTART,
		S_RDIV,
		S_ENUM,
		S_DRAIN
	} state_t;

	state_t state_q;

	// problem state
	logic [CW-1:0]        cnt_q;
	logic                 ovf_q;
	logic [RES_W-1:0]     target_q;
	logic [MOD_W-1:0]     mod_q;

	// sweep control
	logic [AW-1:0]        idx_q;
	logic [KW-1:0]        k_q;
	logic [MAX_ITEMS-1:0] g_q;

	// result registers
	logic                 done_q;
	logic                 tmi_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 found_q;

	// weight memory
	logic [RES_W-1:0]     mem [MAX_ITEMS];
	logic [RES_W-1:0]     rd_q;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;

	// subset walk pipeline
	logic                 v_s1;
	logic                 add_s1;
	logic                 v_s2;
	logic [RES_W-1:0]     sum_q;
	logic [RES_W-1:0]     sum_nxt;
	logic [MOD_W-1:0]     sum_ext;
	logic [MOD_W-1:0]     w_ext;
	logic [MOD_W-1:0]     add_t;

	div_req_t             div_req;
	logic                 div_done;
	logic [RES_W-1:0]     div_rem;

	logic                 accept;
	logic                 full;
	logic                 at_end;
	logic                 enum_step;
	logic [AW-1:0]        step_idx;
	logic [KW-1:0]        lim;

	// lowest set bit of the subset counter picks the weight that flips
	function automatic logic [AW-1:0] lowest_set(input logic [KW-1:0] k);
		logic [AW-1:0] r;
		r = '0;
		for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
			if (k[i]) begin
				r = AW'(i);
			end
		end
		return r;
	endfunction

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign full      = (cnt_q == CW'(MAX_ITEMS));
	assign step_idx  = lowest_set(k_q);
	assign lim       = KW'(1) << cnt_q;
	assign at_end    = (k_q == lim);
	assign enum_step = (state_q == S_ENUM) && !at_end;

	// effective modulus is kept ready: zero acts as one, large values clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET;
		end else if (modulus_we) begin
			if (modulus_wdata == '0) begin
				mod_q <= MOD_W'(1);
			end else if (modulus_wdata > MOD_LIMIT) begin
				mod_q <= MOD_LIMIT;
			end else begin
				mod_q <= modulus_wdata;
			end
		end
	end

	// remainder unit: new weight or target from the input, or a stored
	// weight read back for reduction with the current modulus
	always_comb begin
		div_req.start    = (accept && (last || !full)) || (state_q == S_RSTART);
		div_req.dividend = (state_q == S_RSTART) ? VALUE_W'(rd_q) : value;
		div_req.divisor  = mod_q;
	end

	msc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.rem    (div_rem)
	);

	// memory ports
	assign rd_addr = (state_q == S_ENUM) ? step_idx : idx_q;
	assign wr_en   = div_done && ((state_q == S_WDIV) || (state_q == S_RDIV));
	assign wr_addr = (state_q == S_WDIV) ? cnt_q[AW-1:0] : idx_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= div_rem;
		end
		rd_q <= mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			target_q <= '0;
			idx_q    <= '0;
			k_q      <= '0;
			g_q      <= '0;
			done_q   <= 1'b0;
			tmi_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (last) begin
							state_q <= S_TDIV;
						end else if (!full) begin
							state_q <= S_WDIV;
						end else begin
							// store full: weight dropped
							ovf_q <= 1'b1;
						end
					end
				end
				S_WDIV: begin
					if (div_done) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_IDLE;
					end
				end
				S_TDIV: begin
					if (div_done) begin
						target_q <= div_rem;
						if (cnt_q == '0) begin
							// empty problem answers at once
							done_q  <= 1'b1;
							tmi_q   <= ovf_q;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= '0;
							state_q <= S_RREAD;
						end
					end
				end
				S_RREAD: begin
					state_q <= S_RSTART;
				end
				S_RSTART: begin
					state_q <= S_RDIV;
				end
				S_RDIV: begin
					if (div_done) begin
						if (CW'(idx_q) + CW'(1) == cnt_q) begin
							k_q     <= KW'(1);
							g_q     <= '0;
							state_q <= S_ENUM;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= S_RREAD;
						end
					end
				end
				S_ENUM: begin
					if (at_end) begin
						state_q <= S_DRAIN;
					end else begin
						k_q           <= k_q + KW'(1);
						g_q[step_idx] <= ~g_q[step_idx];
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						done_q  <= 1'b1;
						tmi_q   <= ovf_q;
						ovf_q   <= 1'b0;
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// stage 1 issues the read; the flipped weight joins or leaves the subset
	always_ff @(posedge clk) begin
		add_s1 <= ~g_q[step_idx];
	end

	// modular add or subtract of one residue, both operands below the modulus
	always_comb begin
		sum_ext = MOD_W'(sum_q);
		w_ext   = MOD_W'(rd_q);
		add_t   = sum_ext + w_ext;
		if (add_s1) begin
			if (add_t >= mod_q) begin
				sum_nxt = RES_W'(add_t - mod_q);
			end else begin
				sum_nxt = RES_W'(add_t);
			end
		end else begin
			if (sum_ext >= w_ext) begin
				sum_nxt = RES_W'(sum_ext - w_ext);
			end else begin
				sum_nxt = RES_W'(sum_ext + mod_q - w_ext);
			end
		end
	end

	// stage 2 updates the running sum, stage 3 compares and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			sum_q   <= '0;
			count_q <= '0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= enum_step;
			v_s2 <= v_s1;
			if ((state_q == S_TDIV) && div_done) begin
				sum_q   <= '0;
				count_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (v_s1) begin
					sum_q <= sum_nxt;
				end
				if (v_s2 && (sum_q == target_q)) begin
					found_q <= 1'b1;
					// saturating count
					if (count_q != '1) begin
						count_q <= count_q + COUNT_W'(1);
					end
				end
			end
		end
	end

	assign done           = done_q;
	assign match_count    = count_q;
	assign found          = found_q;
	assign too_many_items = tmi_q;

endmodule

// ===== rtl/msc_checker.sv =====
`include "assert_macros.svh"

module msc_checker
	import msc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               last,
	input logic               done,
	input logic [COUNT_W-1:0] match_count,
	input logic               found
);

	// found flag agrees with the count it comes with
	`MSC_ASSERT(a_found_count, done |-> (found == (match_count != '0)), "found and count disagree")

	// a result only follows work in progress
	`MSC_ASSERT(a_done_after_busy, done |-> $past(busy), "result without a pending target")

	// a target always starts a search
	`MSC_ASSERT(a_target_busy, (start && !busy && last) |=> busy, "target item not taken up")

	// a result is a single cycle wide
	`MSC_ASSERT(a_done_single, done |=> !done, "result shown twice")

endmodule

bind modular_subset_sum_counter_core msc_checker u_msc_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import msc_pkg::*;

	localparam int SLOTS = MAX_ITEMS_DEF;
	// cycles a weight item may keep the block at work after the last result
	localparam int WEIGHT_SETTLE = 64;

	// expected result of one problem
	typedef struct {
		logic [COUNT_W-1:0] count;
		logic               hit;
		logic               overflow;
	} tally_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [VALUE_W-1:0] value = '0;
	logic               last = 1'b0;
	logic               done;
	logic [COUNT_W-1:0] match_count;
	logic               found;
	logic               too_many_items;
	logic               modulus_we = 1'b0;
	logic [MOD_W-1:0]   modulus_wdata = '0;

	// predictor state, mirrors the block after reset
	logic [MOD_W-1:0]   mod_reg = MOD_RESET;
	logic [RES_W-1:0]   residues [SLOTS];
	int unsigned        stored = 0;
	bit                 weight_lost = 1'b0;

	tally_t             tally_q [$];
	int unsigned        mismatches = 0;
	int unsigned        items_sent = 0;
	bit                 idle_on = 1'b1;

	modular_subset_sum_counter_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.value          (value),
		.last           (last),
		.done           (done),
		.match_count    (match_count),
		.found          (found),
		.too_many_items (too_many_items),
		.modulus_we     (modulus_we),
		.modulus_wdata  (modulus_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#3000000;
		$display("tb failed");
		$finish;
	end

	// modulus as the search sees it: zero acts as one, large values clamp to 2^30
	function automatic longint unsigned eff_mod();
		longint unsigned m;
		m = 64'(mod_reg);
		if (m == 0)
			m = 1;
		if (m > MOD_LIMIT)
			m = 64'(MOD_LIMIT);
		return m;
	endfunction

	// walk every non-empty subset in gray-code order, one weight toggled per step
	function automatic tally_t count_matches(input logic [VALUE_W-1:0] tgt_raw);
		longint unsigned m;
		longint unsigned tgt;
		longint unsigned total;
		longint unsigned hits;
		int unsigned     limit;
		int unsigned     g;
		int              k;
		bit              member [SLOTS];
		tally_t          t;
		m = eff_mod();
		tgt = longint'(tgt_raw) % m;
		total = 0;
		hits = 0;
		limit = 1 << stored;
		foreach (member[i])
			member[i] = 1'b0;
		for (g = 1; g < limit; g++) begin
			k = 0;
			while (((g >> k) & 1) == 0)
				k++;
			member[k] = !member[k];
			if (member[k])
				total += residues[k];
			else
				total -= residues[k];
			if (total % m == tgt)
				hits++;
		end
		t.count = (hits > 65535) ? 16'hFFFF : hits[COUNT_W-1:0];
		t.hit = (hits != 0);
		t.overflow = weight_lost;
		return t;
	endfunction

	// update the predictor with one accepted item
	function automatic void take_item(input logic [VALUE_W-1:0] v, input logic l);
		longint unsigned r;
		if (!l) begin
			if (stored < SLOTS) begin
				r = longint'(v) % eff_mod();
				residues[stored] = r[RES_W-1:0];
				stored++;
			end else begin
				weight_lost = 1'b1;
			end
		end else begin
			tally_q.insert(tally_q.size(), count_matches(v));
			stored = 0;
			weight_lost = 1'b0;
		end
	endfunction

	function automatic logic [VALUE_W-1:0] rand_value();
		logic [VALUE_W-1:0] r;
		r = {8'($urandom), 32'($urandom)};
		return r;
	endfunction

	// send one item, with an optional idle gap in front of it
	task automatic send_item(input logic [VALUE_W-1:0] v, input logic l);
		int gap;
		if (idle_on && $urandom_range(0, 99) < 24) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		last <= l;
		do @(posedge clk); while (busy);
		take_item(v, l);
		items_sent++;
	endtask

	// hold off until every result is in and a pending weight has been stored
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (tally_q.size() != 0 || busy);
		repeat (WEIGHT_SETTLE) @(posedge clk);
	endtask

	// call only after settle, with start already low
	task automatic write_modulus(input logic [MOD_W-1:0] m);
		modulus_we <= 1'b1;
		modulus_wdata <= m;
		@(posedge clk);
		mod_reg = m;
		modulus_we <= 1'b0;
		@(posedge clk);
	endtask

	// target equal to a random subset sum of the stored residues, plus a few moduli
	function automatic logic [VALUE_W-1:0] pick_target();
		longint unsigned s;
		s = 0;
		for (int i = 0; i < stored; i++)
			if ($urandom_range(0, 1))
				s += residues[i];
		s += $urandom_range(0, 3) * eff_mod();
		return s[VALUE_W-1:0];
	endfunction

	function automatic logic [MOD_W-1:0] pick_modulus();
		logic [MOD_W-1:0] m;
		case ($urandom_range(0, 6))
			0: m = MOD_W'($urandom_range(1, 16));
			1: m = MOD_W'($urandom_range(17, 1000));
			2: m = 31'($urandom);
			3: m = MOD_LIMIT;
			4: m = MOD_W'(MOD_LIMIT + $urandom_range(1, 1000));
			5: m = MOD_W'($urandom_range(0, 1));
			default: m = MOD_W'({MOD_W{1'b1}} - $urandom_range(0, 3));
		endcase
		return m;
	endfunction

	// bare target, then extreme weights under the reset modulus
	task automatic test_empty_and_extremes();
		send_item(rand_value(), 1'b1);
		send_item('0, 1'b0);
		send_item('1, 1'b0);
		send_item('1, 1'b1);
	endtask

	// modulus zero: every subset matches
	task automatic test_modulus_zero();
		settle();
		write_modulus('0);
		send_item(rand_value(), 1'b0);
		send_item(rand_value(), 1'b0);
		send_item(rand_value(), 1'b1);
	endtask

	// all-ones modulus clamps to 2^30
	task automatic test_modulus_clamp();
		settle();
		write_modulus({MOD_W{1'b1}});
		send_item('1, 1'b0);
		send_item(40'h00_3FFF_FFFF, 1'b0);
		send_item(pick_target(), 1'b1);
	endtask

	// weights stored under one modulus, the search re-reduces them with the new one
	task automatic test_modulus_change_mid_problem();
		settle();
		write_modulus(31'd1000);
		send_item(40'd1700, 1'b0);
		settle();
		write_modulus(31'd300);
		send_item(40'd100, 1'b1);
	endtask

	// one weight past the store with modulus one: count pegs at the top, overflow set
	task automatic test_store_overflow();
		settle();
		write_modulus(31'd1);
		for (int i = 0; i <= SLOTS; i++)
			send_item(rand_value(), 1'b0);
		send_item(rand_value(), 1'b1);
	endtask

	// random problems, mostly small, some medium, at most one at or past the store size
	task automatic test_random_problems();
		int n;
		int r;
		int big_left;
		big_left = 1;
		while (items_sent < 140) begin
			// long stretch with no idle gaps and no pauses
			idle_on = !(items_sent >= 60 && items_sent < 95);
			if (idle_on && $urandom_range(0, 9) < 3) begin
				settle();
				write_modulus(pick_modulus());
			end
			r = $urandom_range(0, 19);
			if (r == 0 && big_left > 0) begin
				n = $urandom_range(SLOTS, SLOTS + 2);
				big_left--;
			end else if (r < 3) begin
				n = $urandom_range(9, 12);
			end else begin
				n = $urandom_range(0, 6);
			end
			for (int i = 0; i < n; i++) begin
				send_item($urandom_range(0, 1) ? rand_value() : VALUE_W'($urandom_range(0, 100)),
					1'b0);
				// occasional modulus change in the middle of a problem
				if (idle_on && $urandom_range(0, 39) == 0) begin
					settle();
					write_modulus(pick_modulus());
				end
			end
			// sometimes drain completely before the target
			if (idle_on && $urandom_range(0, 9) == 0)
				settle();
			send_item(($urandom_range(0, 9) < 6) ? pick_target() : rand_value(), 1'b1);
		end
	endtask

	// result check, sampled mid-cycle so it never races the item side
	always @(negedge clk) begin
		tally_t want;
		if (arst_n && done) begin
			if (tally_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: count %0d found %0b overflow %0b",
						match_count, found, too_many_items);
			end else begin
				want = tally_q.pop_front();
				if (match_count !== want.count || found !== want.hit ||
					too_many_items !== want.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0b/%0b, got %0d/%0b/%0b",
							want.count, want.hit, want.overflow,
							match_count, found, too_many_items);
				end
			end
		end
	end

	initial begin
		// hold reset, then release it
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_extremes();
		test_modulus_zero();
		test_modulus_clamp();
		test_modulus_change_mid_problem();
		test_store_overflow();
		test_random_problems();

		// drain, then give the block time to show anything stray
		start <= 1'b0;
		do @(posedge clk); while (tally_q.size() != 0);
		repeat (WEIGHT_SETTLE) @(posedge clk);

		if (mismatches == 0 && tally_q.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
